// File: sv/button_tap_hold_double_detector_core_defines.svh
// Assertion macros shared by the checker of the gesture detector core.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef BUTTON_TAP_HOLD_DOUBLE_DETECTOR_CORE_DEFINES_SVH
`define BUTTON_TAP_HOLD_DOUBLE_DETECTOR_CORE_DEFINES_SVH

// same-cycle implication
`define BTD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BTD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/btd_pkg.sv
// Types, codes and constants of the tap/hold/double-tap detector core.
// No dependencies; used by every module of the block.
`default_nettype none

package btd_pkg;

	localparam int NUM_CONTROLS = 16;
	localparam int SLOT_W = (NUM_CONTROLS > 1) ? $clog2(NUM_CONTROLS) : 1;
	localparam int RANGE_W = 6;

	localparam int CTL_W = 4;
	localparam int DLY_W = 16;

	localparam logic [DLY_W-1:0] HOLD_MIN = 16'd250;
	localparam logic [DLY_W-1:0] HOLD_DEFAULT = 16'd600;
	localparam logic [DLY_W-1:0] DBL_MIN = 16'd80;
	localparam logic [DLY_W-1:0] DBL_DEFAULT = 16'd320;

	// input kinds (tuser)
	localparam logic [1:0] ACT_EVENT = 2'd0;
	localparam logic [1:0] ACT_TICK = 2'd1;
	localparam logic [1:0] ACT_CANCEL = 2'd2;

	// fired action kinds (tuser)
	localparam logic [1:0] WH_PRIMARY = 2'd0;
	localparam logic [1:0] WH_HOLD = 2'd1;
	localparam logic [1:0] WH_DOUBLE = 2'd2;

	// result tdata bit positions
	localparam int OUT_PRESSED_BIT = 4;
	localparam int OUT_VALUE_BIT = 5;

	typedef struct packed {
		logic [DLY_W-1:0] double_delay;
		logic [DLY_W-1:0] hold_delay;
		logic             double_assigned;
		logic             hold_assigned;
		logic             latching;
		logic             pressed;
		logic [CTL_W-1:0] control;
	} in_data_t;

	typedef struct packed {
		logic [1:0]       pad;
		logic             value;
		logic             pressed_res;
		logic [CTL_W-1:0] control_res;
	} out_data_t;

	typedef struct packed {
		logic [1:0]       action;
		logic             pressed;
		logic             latching;
		logic             hold_assigned;
		logic             double_assigned;
		logic [DLY_W-1:0] hold_delay;
		logic [DLY_W-1:0] double_delay;
	} cmd_t;

	typedef struct packed {
		logic             held;
		logic             fired;
		logic             armed;
		logic             tap_pend;
		logic             swallow;
		logic [DLY_W-1:0] hold_cnt;
		logic [DLY_W-1:0] tap_cnt;
	} slot_t;

	typedef struct packed {
		logic [CTL_W-1:0] control;
		logic [1:0]       which;
		logic             pressed;
		logic             value;
	} res_t;

	typedef struct packed {
		logic emit;
		res_t res;
	} step_out_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

endpackage

`default_nettype wire

// File: sv/btd_slot_file.sv
// Per-control gesture state: flags in reset flops, countdowns as plain storage.
// One read port and one write port at the same slot index. Depends on btd_pkg.
`default_nettype none

module btd_slot_file (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [btd_pkg::SLOT_W-1:0] idx,
	output btd_pkg::slot_t                 rdata,
	input  wire logic                      we,
	input  wire btd_pkg::slot_t            wdata
);

	logic                      held_q     [btd_pkg::NUM_CONTROLS];
	logic                      fired_q    [btd_pkg::NUM_CONTROLS];
	logic                      armed_q    [btd_pkg::NUM_CONTROLS];
	logic                      tap_pend_q [btd_pkg::NUM_CONTROLS];
	logic                      swallow_q  [btd_pkg::NUM_CONTROLS];
	logic [btd_pkg::DLY_W-1:0] hold_cnt_q [btd_pkg::NUM_CONTROLS];
	logic [btd_pkg::DLY_W-1:0] tap_cnt_q  [btd_pkg::NUM_CONTROLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < btd_pkg::NUM_CONTROLS; i++) begin
				held_q[i]     <= 1'b0;
				fired_q[i]    <= 1'b0;
				armed_q[i]    <= 1'b0;
				tap_pend_q[i] <= 1'b0;
				swallow_q[i]  <= 1'b0;
			end
		end else if (we) begin
			held_q[idx]     <= wdata.held;
			fired_q[idx]    <= wdata.fired;
			armed_q[idx]    <= wdata.armed;
			tap_pend_q[idx] <= wdata.tap_pend;
			swallow_q[idx]  <= wdata.swallow;
		end
	end

	// countdowns are only read while their flag is set
	always_ff @(posedge clk) begin
		if (we) begin
			hold_cnt_q[idx] <= wdata.hold_cnt;
			tap_cnt_q[idx]  <= wdata.tap_cnt;
		end
	end

	always_comb begin
		rdata.held     = held_q[idx];
		rdata.fired    = fired_q[idx];
		rdata.armed    = armed_q[idx];
		rdata.tap_pend = tap_pend_q[idx];
		rdata.swallow  = swallow_q[idx];
		rdata.hold_cnt = hold_cnt_q[idx];
		rdata.tap_cnt  = tap_cnt_q[idx];
	end

endmodule

`default_nettype wire

// File: sv/btd_step.sv
// Shared slot update unit: one countdown decrement/compare and the gesture rules
// for one control slot per cycle. Depends on btd_pkg.
`default_nettype none

module btd_step (
	input  wire btd_pkg::cmd_t             cmd,
	input  wire logic [btd_pkg::SLOT_W-1:0] idx,
	input  wire btd_pkg::slot_t            cur,
	output btd_pkg::slot_t                 nxt,
	output btd_pkg::step_out_t             out
);

	logic                      hold_act;
	logic [btd_pkg::DLY_W-1:0] cnt_sel;
	logic [btd_pkg::DLY_W-1:0] cnt_dec;
	logic                      cnt_gt1;

	// a held control never has a pending tap, so one decrementer serves both
	assign hold_act = cur.held & ~cur.fired & cur.armed;
	assign cnt_sel  = hold_act ? cur.hold_cnt : cur.tap_cnt;
	assign cnt_gt1  = cnt_sel > 16'd1;
	assign cnt_dec  = cnt_sel - 16'd1;

	always_comb begin
		nxt = cur;
		out.emit = 1'b0;
		out.res.control = btd_pkg::CTL_W'(idx);
		out.res.which = btd_pkg::WH_PRIMARY;
		out.res.pressed = 1'b1;
		out.res.value = 1'b0;

		unique case (cmd.action)
			btd_pkg::ACT_TICK: begin
				if (hold_act) begin
					if (cnt_gt1) begin
						nxt.hold_cnt = cnt_dec;
					end else begin
						nxt.hold_cnt = '0;
						nxt.fired = 1'b1;
						nxt.tap_pend = 1'b0;
						nxt.tap_cnt = '0;
						out.emit = 1'b1;
						out.res.which = btd_pkg::WH_HOLD;
					end
				end else if (cur.tap_pend) begin
					if (cnt_gt1) begin
						nxt.tap_cnt = cnt_dec;
					end else begin
						nxt.tap_cnt = '0;
						nxt.tap_pend = 1'b0;
						out.emit = 1'b1;
					end
				end
			end
			btd_pkg::ACT_CANCEL: begin
				nxt.held = 1'b0;
				nxt.fired = 1'b0;
				nxt.armed = 1'b0;
				nxt.hold_cnt = '0;
				nxt.tap_pend = 1'b0;
				nxt.tap_cnt = '0;
			end
			btd_pkg::ACT_EVENT: begin
				if (cmd.latching) begin
					out.emit = 1'b1;
					out.res.pressed = cmd.pressed;
					out.res.value = cmd.pressed;
				end else if (cmd.pressed) begin
					nxt.swallow = 1'b0;
					if (cur.tap_pend) begin
						nxt.tap_pend = 1'b0;
						nxt.tap_cnt = '0;
						if (cmd.double_assigned) begin
							nxt.swallow = 1'b1;
							out.emit = 1'b1;
							out.res.which = btd_pkg::WH_DOUBLE;
							out.res.value = 1'b1;
						end
					end else if (cur.held) begin
						nxt.swallow = 1'b0;
					end else if (cmd.hold_assigned || cmd.double_assigned) begin
						nxt.held = 1'b1;
						nxt.fired = 1'b0;
						nxt.armed = cmd.hold_assigned;
						nxt.hold_cnt = cmd.hold_delay;
					end else begin
						out.emit = 1'b1;
						out.res.value = 1'b1;
					end
				end else begin
					if (cur.swallow) begin
						nxt.swallow = 1'b0;
					end else if (cur.held) begin
						nxt.held = 1'b0;
						nxt.fired = 1'b0;
						nxt.armed = 1'b0;
						nxt.hold_cnt = '0;
						if (!cur.fired) begin
							if (cmd.double_assigned) begin
								nxt.tap_pend = 1'b1;
								nxt.tap_cnt = cmd.double_delay;
							end else begin
								out.emit = 1'b1;
							end
						end
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: sv/button_tap_hold_double_detector_core.sv
// Top level of the tap/hold/double-tap detector: sequencer, slot file, step unit
// and result registers. Depends on btd_pkg, btd_slot_file and btd_step.
//
// Usage:
//   s_axis carries one item per transfer: tuser is the kind (button event,
//   one-millisecond tick, cancel), tdata the control index and its binding.
//   m_axis carries the fired actions; tlast marks the final result of an item.
//   An item that fires nothing produces no transfer at all.
//   An event or cancel touches one slot and passes through the RUN and FLUSH
//   states before ready is high again. A tick walks all NUM_CONTROLS slots,
//   one per cycle through the shared step unit unless a stall holds the walk.
//   s_axis_tready is high only while the sequencer is idle.
//   Results leave through a one-entry hold register and the m_axis register;
//   when the receiver stalls and both are full, the slot walk pauses on the
//   slot that has a new result until m_axis_tready frees the output.
//   An event's result goes through the hold register into the m_axis register.
//   The output register may still hold the last result while a new item is
//   taken.
//   Reset clears all gesture flags and the sequencer; no clearing pass.
`default_nettype none

module button_tap_hold_double_detector_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// control, pressed, latching, hold_assigned, double_assigned,
	// hold_delay, double_delay
	input  wire logic [39:0] s_axis_tdata,
	// action
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// control_res, pressed_res, value, zero pad
	output logic [7:0]       m_axis_tdata,
	// which_action
	output logic [1:0]       m_axis_tuser,
	output logic             m_axis_tlast
);

	btd_pkg::state_t             state_q;
	btd_pkg::cmd_t               cmd_q;
	logic                        apply_q;
	logic [btd_pkg::SLOT_W-1:0]  idx_q;
	btd_pkg::res_t               pend_res_q;
	logic                        pend_q;
	btd_pkg::res_t               out_res_q;
	logic                        out_last_q;
	logic                        out_valid_q;

	btd_pkg::in_data_t           in_data;
	btd_pkg::out_data_t          out_data;
	btd_pkg::slot_t              slot_cur;
	btd_pkg::slot_t              slot_nxt;
	btd_pkg::step_out_t          step_out;
	logic                        in_xfer;
	logic                        in_range;
	logic                        out_free;
	logic                        emit;
	logic                        stall;
	logic                        walk_done;
	logic                        out_load;
	btd_pkg::res_t               out_load_res;
	logic                        out_load_last;

	assign in_data  = btd_pkg::in_data_t'(s_axis_tdata);
	assign in_xfer  = s_axis_tvalid & s_axis_tready;
	assign in_range = btd_pkg::RANGE_W'(in_data.control) <
		btd_pkg::RANGE_W'(btd_pkg::NUM_CONTROLS);
	assign out_free = ~out_valid_q | m_axis_tready;

	btd_slot_file u_slot_file (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (idx_q),
		.rdata  (slot_cur),
		.we     (state_q == btd_pkg::ST_RUN && apply_q && !stall),
		.wdata  (slot_nxt)
	);

	btd_step u_step (
		.cmd (cmd_q),
		.idx (idx_q),
		.cur (slot_cur),
		.nxt (slot_nxt),
		.out (step_out)
	);

	assign emit      = apply_q & step_out.emit;
	assign stall     = emit & pend_q & ~out_free;
	assign walk_done = (cmd_q.action != btd_pkg::ACT_TICK) ||
		(idx_q == btd_pkg::SLOT_W'(btd_pkg::NUM_CONTROLS - 1));

	always_comb begin
		out_load = 1'b0;
		out_load_res = pend_res_q;
		out_load_last = 1'b0;
		unique case (state_q)
			btd_pkg::ST_RUN: begin
				out_load = emit & pend_q & ~stall;
			end
			btd_pkg::ST_FLUSH: begin
				out_load = pend_q & out_free;
				out_load_last = 1'b1;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btd_pkg::ST_IDLE;
			apply_q <= 1'b0;
			pend_q <= 1'b0;
			idx_q <= '0;
		end else begin
			unique case (state_q)
				btd_pkg::ST_IDLE: begin
					if (in_xfer) begin
						state_q <= btd_pkg::ST_RUN;
						if (s_axis_tuser == btd_pkg::ACT_TICK) begin
							apply_q <= 1'b1;
							idx_q <= '0;
						end else begin
							apply_q <= in_range && (s_axis_tuser == btd_pkg::ACT_EVENT ||
								s_axis_tuser == btd_pkg::ACT_CANCEL);
							idx_q <= btd_pkg::SLOT_W'(in_data.control);
						end
					end
				end
				btd_pkg::ST_RUN: begin
					if (!stall) begin
						if (emit) begin
							pend_q <= 1'b1;
						end
						if (walk_done) begin
							state_q <= btd_pkg::ST_FLUSH;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				btd_pkg::ST_FLUSH: begin
					if (!pend_q) begin
						state_q <= btd_pkg::ST_IDLE;
					end else if (out_free) begin
						pend_q <= 1'b0;
						state_q <= btd_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= btd_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// item capture with effective delays
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q.action <= s_axis_tuser;
			cmd_q.pressed <= in_data.pressed;
			cmd_q.latching <= in_data.latching;
			cmd_q.hold_assigned <= in_data.hold_assigned;
			cmd_q.double_assigned <= in_data.double_assigned;
			cmd_q.hold_delay <= (in_data.hold_delay < btd_pkg::HOLD_MIN) ?
				btd_pkg::HOLD_DEFAULT : in_data.hold_delay;
			cmd_q.double_delay <= (in_data.double_delay < btd_pkg::DBL_MIN) ?
				btd_pkg::DBL_DEFAULT : in_data.double_delay;
		end
		if (state_q == btd_pkg::ST_RUN && emit && !stall) begin
			pend_res_q <= step_out.res;
		end
		if (out_load) begin
			out_res_q <= out_load_res;
			out_last_q <= out_load_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load | (out_valid_q & ~m_axis_tready);
		end
	end

	always_comb begin
		out_data.pad = 2'b00;
		out_data.value = out_res_q.value;
		out_data.pressed_res = out_res_q.pressed;
		out_data.control_res = out_res_q.control;
	end

	assign s_axis_tready = (state_q == btd_pkg::ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data;
	assign m_axis_tuser  = out_res_q.which;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// File: sv/btd_chk.sv
// Port-level checker for the gesture detector core, bound to the top level.
// Depends on btd_pkg and button_tap_hold_double_detector_core_defines.svh.
`default_nettype none

`include "button_tap_hold_double_detector_core_defines.svh"

module btd_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [7:0]  m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser,
	input wire logic        m_axis_tlast
);

	logic res_value;
	logic res_pressed;
	logic in_xfer;

	assign res_value   = m_axis_tdata[btd_pkg::OUT_VALUE_BIT];
	assign res_pressed = m_axis_tdata[btd_pkg::OUT_PRESSED_BIT];
	assign in_xfer     = s_axis_tvalid & s_axis_tready;

	`BTD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
	`BTD_ASSERT_NEXT(a_busy_after_xfer, in_xfer, !s_axis_tready, "ready stayed high after a transfer")
	`BTD_ASSERT_IMPL(a_hold_fields, m_axis_tvalid && m_axis_tuser == btd_pkg::WH_HOLD, res_pressed && !res_value, "hold result with bad flags")
	`BTD_ASSERT_IMPL(a_double_fields, m_axis_tvalid && m_axis_tuser == btd_pkg::WH_DOUBLE, res_pressed && res_value && m_axis_tlast, "double-tap result with bad flags")

endmodule

bind button_tap_hold_double_detector_core btd_chk u_btd_chk (.*);

`default_nettype wire

// File: verif/btd_gesture_checker.sv
`timescale 1ns / 100ps
// Checker for the tap/hold/double-tap detector: watches both stream ports, keeps its
// own per-button gesture state and checks every fired action in order.
// Depends on btd_pkg.
import btd_pkg::*;

module btd_gesture_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,
	input  wire logic [1:0]  s_axis_tuser,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [7:0]  m_axis_tdata,
	input  wire logic [1:0]  m_axis_tuser,
	input  wire logic        m_axis_tlast,
	output int               exp_left,
	output int               fail_cnt,
	output int               res_seen,
	output int               hold_seen,
	output int               dbl_seen
);

	typedef struct packed {
		logic [CTL_W-1:0] ctl;
		logic [1:0]       which;
		logic             pressed;
		logic             value;
		logic             last;
	} fired_t;

	bit             held [NUM_CONTROLS];
	bit             hold_done [NUM_CONTROLS];
	bit             armed [NUM_CONTROLS];
	bit [DLY_W-1:0] hold_left [NUM_CONTROLS];
	bit             tap_wait [NUM_CONTROLS];
	bit [DLY_W-1:0] tap_left [NUM_CONTROLS];
	bit             swallow [NUM_CONTROLS];
	fired_t         fired_q [$];
	int             errors;

	function automatic fired_t action_of(input int c, input logic [1:0] w, input logic p,
			input logic v);
		fired_t f;
		f.ctl = CTL_W'(c);
		f.which = w;
		f.pressed = p;
		f.value = v;
		f.last = 1'b0;
		return f;
	endfunction

	function automatic void drop_hold(input int c);
		held[c] = 1'b0;
		hold_done[c] = 1'b0;
		armed[c] = 1'b0;
		hold_left[c] = '0;
	endfunction

	// one accepted item in, its fired actions appended to fired_q
	function automatic void advance_gestures(input logic [1:0] act, input in_data_t d);
		fired_t           batch [$];
		logic [DLY_W-1:0] hd;
		logic [DLY_W-1:0] dd;
		int               c;
		hd = (d.hold_delay < HOLD_MIN) ? HOLD_DEFAULT : d.hold_delay;
		dd = (d.double_delay < DBL_MIN) ? DBL_DEFAULT : d.double_delay;
		c = int'(d.control);
		if (act == ACT_TICK) begin
			for (int i = 0; i < NUM_CONTROLS; i++) begin
				if (held[i] && !hold_done[i] && armed[i]) begin
					if (hold_left[i] > 1) begin
						hold_left[i] = hold_left[i] - 1'b1;
					end else begin
						hold_left[i] = '0;
						hold_done[i] = 1'b1;
						tap_wait[i] = 1'b0;
						tap_left[i] = '0;
						batch = {batch, action_of(i, WH_HOLD, 1'b1, 1'b0)};
						continue;
					end
				end
				if (tap_wait[i]) begin
					if (tap_left[i] > 1) begin
						tap_left[i] = tap_left[i] - 1'b1;
					end else begin
						tap_left[i] = '0;
						tap_wait[i] = 1'b0;
						batch = {batch, action_of(i, WH_PRIMARY, 1'b1, 1'b0)};
					end
				end
			end
		end else if (act == ACT_CANCEL) begin
			if (c < NUM_CONTROLS) begin
				drop_hold(c);
				tap_wait[c] = 1'b0;
				tap_left[c] = '0;
			end
		end else if (act == ACT_EVENT && c < NUM_CONTROLS) begin
			if (d.latching) begin
				batch = {batch, action_of(c, WH_PRIMARY, d.pressed, d.pressed)};
			end else if (d.pressed) begin
				swallow[c] = 1'b0;
				if (tap_wait[c]) begin
					tap_wait[c] = 1'b0;
					tap_left[c] = '0;
					if (d.double_assigned) begin
						swallow[c] = 1'b1;
						batch = {batch, action_of(c, WH_DOUBLE, 1'b1, 1'b1)};
					end
				end else if (!held[c]) begin
					if (d.hold_assigned || d.double_assigned) begin
						held[c] = 1'b1;
						hold_done[c] = 1'b0;
						armed[c] = d.hold_assigned;
						hold_left[c] = hd;
					end else begin
						batch = {batch, action_of(c, WH_PRIMARY, 1'b1, 1'b1)};
					end
				end
			end else if (swallow[c]) begin
				swallow[c] = 1'b0;
			end else if (held[c]) begin
				if (!hold_done[c]) begin
					if (d.double_assigned) begin
						tap_wait[c] = 1'b1;
						tap_left[c] = dd;
					end else begin
						batch = {batch, action_of(c, WH_PRIMARY, 1'b1, 1'b0)};
					end
				end
				drop_hold(c);
			end
		end
		if (batch.size() > 0)
			batch[batch.size()-1].last = 1'b1;
		fired_q = {fired_q, batch};
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		fired_t    want;
		out_data_t got;
		if (!arst_n) begin
			fired_q.delete();
			for (int i = 0; i < NUM_CONTROLS; i++) begin
				drop_hold(i);
				tap_wait[i] = 1'b0;
				tap_left[i] = '0;
				swallow[i] = 1'b0;
			end
		end else begin
			// result transfer first: it belongs to an older item
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				res_seen <= res_seen + 1;
				if (m_axis_tuser == WH_HOLD)
					hold_seen <= hold_seen + 1;
				if (m_axis_tuser == WH_DOUBLE)
					dbl_seen <= dbl_seen + 1;
				if (fired_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("checker: %0t unexpected action ctl %0d kind %0d", $time,
							got.control_res, m_axis_tuser);
				end else begin
					want = fired_q.pop_front();
					if (got.control_res !== want.ctl || m_axis_tuser !== want.which ||
							got.pressed_res !== want.pressed || got.value !== want.value ||
							m_axis_tlast !== want.last) begin
						errors++;
						if (errors <= 10)
							$display({"checker: %0t mismatch, expected ctl %0d kind %0d ",
								"pressed %0b value %0b last %0b, got ctl %0d kind %0d ",
								"pressed %0b value %0b last %0b"}, $time,
								want.ctl, want.which, want.pressed, want.value, want.last,
								got.control_res, m_axis_tuser, got.pressed_res, got.value,
								m_axis_tlast);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				advance_gestures(s_axis_tuser, s_axis_tdata);
			exp_left <= fired_q.size();
			fail_cnt <= errors;
		end
	end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Top of the detector testbench: clock, reset, gesture stimulus with bursty input
// and patterned output back-pressure. Depends on btd_pkg, btd_gesture_checker
// and button_tap_hold_double_detector_core.
import btd_pkg::*;

module tb;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int         RANDOM_ITEMS = 410;

	typedef enum int {RX_FREE, RX_COIN, RX_QUARTER, RX_SLOW} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = ACT_EVENT;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	int exp_left;
	int fail_cnt;
	int res_seen;
	int hold_seen;
	int dbl_seen;
	int n_items;
	int n_ticks;
	int burst_left;

	rx_mode_t rx_mode = RX_FREE;
	int       rx_left;

	// per-button stimulus plan
	bit               down [NUM_CONTROLS];
	int               release_at [NUM_CONTROLS];
	bit               bind_latch [NUM_CONTROLS];
	bit               bind_hold [NUM_CONTROLS];
	bit               bind_dbl [NUM_CONTROLS];
	logic [DLY_W-1:0] bind_hd [NUM_CONTROLS];
	logic [DLY_W-1:0] bind_dd [NUM_CONTROLS];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	button_tap_hold_double_detector_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	btd_gesture_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.exp_left     (exp_left),
		.fail_cnt     (fail_cnt),
		.res_seen     (res_seen),
		.hold_seen    (hold_seen),
		.dbl_seen     (dbl_seen)
	);

	// receiver back-pressure
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(3));
			rx_left <= $urandom_range(120, 8);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_FREE: m_axis_tready <= 1'b1;
			RX_COIN: m_axis_tready <= 1'($urandom_range(1));
			RX_QUARTER: m_axis_tready <= (rx_left % 4 == 0);
			default: m_axis_tready <= (rx_left % 13 == 0);
		endcase
	end

	task automatic send_item(input logic [1:0] act, input in_data_t d);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		if (act == ACT_TICK)
			n_ticks++;
		if (act != ACT_UNUSED)
			n_items++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(24, 1);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(15, 1);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic button_event(input int c, input bit pr, input bit lt, input bit ho,
			input bit db, input int hd, input int dd);
		in_data_t d;
		d.control = CTL_W'(c);
		d.pressed = pr;
		d.latching = lt;
		d.hold_assigned = ho;
		d.double_assigned = db;
		d.hold_delay = DLY_W'(hd);
		d.double_delay = DLY_W'(dd);
		send_item(ACT_EVENT, d);
	endtask

	task automatic tick();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		send_item(ACT_TICK, raw[39:0]);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (exp_left != 0)
			@(posedge clk);
	endtask

	function automatic void new_binding(input int c);
		int pick;
		bind_latch[c] = ($urandom_range(9) == 0);
		bind_hold[c] = 1'($urandom_range(1));
		bind_dbl[c] = 1'($urandom_range(1));
		pick = $urandom_range(19);
		if (pick < 12)
			bind_hd[c] = DLY_W'($urandom_range(262, 250));
		else if (pick < 15)
			bind_hd[c] = DLY_W'($urandom_range(249));
		else if (pick < 18)
			bind_hd[c] = DLY_W'($urandom);
		else
			bind_hd[c] = '1;
		pick = $urandom_range(19);
		if (pick < 12)
			bind_dd[c] = DLY_W'($urandom_range(100, 80));
		else if (pick < 15)
			bind_dd[c] = DLY_W'($urandom_range(79));
		else if (pick < 18)
			bind_dd[c] = DLY_W'($urandom);
		else
			bind_dd[c] = '1;
	endfunction

	initial begin : stim
		in_data_t    d;
		logic [63:0] raw;
		int          pick;
		int          plan;
		int          c;
		int          base;
		bit          paused;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: cancel on idle button, unused kind, latching both ways,
		// plain press, release not held, double tap with swallowed release,
		// release before hold, repeated press, cancel, tap consumed without double
		d = '0;
		d.control = CTL_W'(3);
		send_item(ACT_CANCEL, d);
		raw = {$urandom, $urandom};
		send_item(ACT_UNUSED, raw[39:0]);
		button_event(0, 1'b1, 1'b1, 1'b0, 1'b0, 0, 0);
		button_event(0, 1'b0, 1'b1, 1'b0, 1'b0, 0, 0);
		button_event(15, 1'b1, 1'b1, 1'b1, 1'b1, 65535, 65535);
		button_event(1, 1'b1, 1'b0, 1'b0, 1'b0, 100, 100);
		button_event(1, 1'b0, 1'b0, 1'b0, 1'b0, 100, 100);
		button_event(2, 1'b1, 1'b0, 1'b0, 1'b1, 0, 0);
		button_event(2, 1'b0, 1'b0, 1'b0, 1'b1, 0, 0);
		button_event(2, 1'b1, 1'b0, 1'b0, 1'b1, 0, 0);
		button_event(2, 1'b0, 1'b0, 1'b0, 1'b1, 0, 0);
		button_event(4, 1'b1, 1'b0, 1'b1, 1'b0, 249, 0);
		button_event(4, 1'b0, 1'b0, 1'b1, 1'b0, 249, 0);
		button_event(5, 1'b1, 1'b0, 1'b1, 1'b1, 300, 90);
		button_event(5, 1'b1, 1'b0, 1'b1, 1'b1, 300, 90);
		d = '0;
		d.control = CTL_W'(5);
		send_item(ACT_CANCEL, d);
		button_event(5, 1'b0, 1'b0, 1'b1, 1'b1, 300, 90);
		button_event(6, 1'b1, 1'b0, 1'b0, 1'b1, 0, 80);
		button_event(6, 1'b0, 1'b0, 1'b0, 1'b1, 0, 80);
		button_event(6, 1'b1, 1'b0, 1'b0, 1'b0, 0, 80);
		button_event(6, 1'b0, 1'b0, 1'b0, 1'b0, 0, 80);
		tick();
		tick();
		// shortest hold delay, kept down long enough to fire
		button_event(15, 1'b1, 1'b0, 1'b1, 1'b0, 250, 79);
		down[15] = 1'b1;
		release_at[15] = n_ticks + 255;
		bind_latch[15] = 1'b0;
		bind_hold[15] = 1'b1;
		bind_dbl[15] = 1'b0;
		bind_hd[15] = 16'd250;
		bind_dd[15] = 16'd79;
		for (int i = 0; i < NUM_CONTROLS - 1; i++)
			new_binding(i);
		drain_results();

		// random gestures with interleaved ticks, noise, cancels
		base = n_items;
		paused = 1'b0;
		while (n_items < base + RANDOM_ITEMS) begin
			if (!paused && n_items >= base + RANDOM_ITEMS / 2) begin
				drain_results();
				paused = 1'b1;
			end
			pick = $urandom_range(99);
			raw = {$urandom, $urandom};
			if (pick < 62) begin
				tick();
			end else if (pick < 88) begin
				if ($urandom_range(3) == 0)
					c = $urandom_range(NUM_CONTROLS - 1);
				else
					c = ((n_items / 90) * 3 + $urandom_range(5)) % NUM_CONTROLS;
				if (!down[c]) begin
					if ($urandom_range(2) == 0)
						new_binding(c);
					plan = $urandom_range(9);
					if (plan < 4)
						release_at[c] = n_ticks + $urandom_range(3);
					else if (plan < 7)
						release_at[c] = n_ticks + $urandom_range(40, 4);
					else
						release_at[c] = n_ticks + $urandom_range(268, 250);
					down[c] = 1'b1;
					button_event(c, 1'b1, bind_latch[c], bind_hold[c], bind_dbl[c],
						bind_hd[c], bind_dd[c]);
				end else if (n_ticks >= release_at[c]) begin
					down[c] = 1'b0;
					button_event(c, 1'b0, bind_latch[c], bind_hold[c], bind_dbl[c],
						bind_hd[c], bind_dd[c]);
				end
			end else if (pick < 93) begin
				send_item(ACT_EVENT, raw[39:0]);
			end else if (pick < 97) begin
				send_item(ACT_CANCEL, raw[39:0]);
			end else begin
				send_item(ACT_UNUSED, raw[39:0]);
			end
		end

		drain_results();
		repeat (40) @(posedge clk);
		$display("tb: %0d items sent, %0d of them ticks; %0d fired actions checked",
			n_items, n_ticks, res_seen);
		$display("tb: %0d hold and %0d double-tap actions among them", hold_seen, dbl_seen);
		if (fail_cnt == 0 && exp_left == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("tb: timeout, %0d actions still outstanding", exp_left);
		$display("tb: FAIL");
		$finish;
	end

endmodule
